/* rtl/probe_fingerprint_device_tracker_assert.svh */
// Assertion macros for the probe fingerprint device tracker.
// Taken in by the RTL files that carry concurrent checks; needs nothing else.
`ifndef PROBE_FINGERPRINT_DEVICE_TRACKER_ASSERT_SVH
`define PROBE_FINGERPRINT_DEVICE_TRACKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PFDT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pfdt: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PFDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pfdt: next-cycle check failed");

`endif

/* rtl/pfdt_pkg.sv */
// Shared types and constants of the probe fingerprint device tracker.
// Used by the interfaces, the table memory and the top level; depends on nothing.
`default_nettype none

package pfdt_pkg;

    localparam int unsigned SEQ_W    = 12;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned FP_W     = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned OIDX_W   = 6;
    localparam int unsigned OCNT_W   = 7;
    localparam int unsigned FRAMES_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam int unsigned MAX_DEVICES_DEF = 64;

    localparam logic [SEQ_W-1:0]    MAX_SEQ_GAP_RST  = 12'd64;
    localparam logic [TIME_W-1:0]   MAX_TIME_GAP_RST = 32'd10000;
    localparam logic [FRAMES_W-1:0] FRAME_LIMIT_RST  = 16'd1000;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEQ_GAP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TIME_GAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT  = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_JOINED  = 2'd0,
        ST_NEW     = 2'd1,
        ST_FULL    = 2'd2,
        ST_IGNORED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPEND,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic [FP_W-1:0]   fingerprint;
        logic [SEQ_W-1:0]  last_seq;
        logic [TIME_W-1:0] last_time;
    } t_entry;

endpackage

`default_nettype wire

/* rtl/pfdt_frame_if.sv */
// Input channel of the tracker: one probe frame per transfer.
// Field widths come from pfdt_pkg.
`default_nettype none

interface pfdt_frame_if;
    logic                          valid;
    logic                          ready;
    logic [pfdt_pkg::SEQ_W-1:0]    seq_number;
    logic [pfdt_pkg::TIME_W-1:0]   time_ms;
    logic [pfdt_pkg::FP_W-1:0]     fingerprint;

    modport source (output valid, seq_number, time_ms, fingerprint, input ready);
    modport sink   (input valid, seq_number, time_ms, fingerprint, output ready);
endinterface

`default_nettype wire

/* rtl/pfdt_result_if.sv */
// Output channel of the tracker: one result per frame transfer.
// Field widths come from pfdt_pkg.
`default_nettype none

interface pfdt_result_if;
    logic                           valid;
    logic                           ready;
    logic [pfdt_pkg::STATUS_W-1:0]  status;
    logic [pfdt_pkg::OIDX_W-1:0]    device_index;
    logic [pfdt_pkg::OCNT_W-1:0]    device_count;

    modport source (output valid, status, device_index, device_count, input ready);
    modport sink   (input valid, status, device_index, device_count, output ready);
endinterface

`default_nettype wire

/* rtl/pfdt_table.sv */
// Device table memory: one write port, one read port with registered data.
// Entry layout from pfdt_pkg::t_entry.
`default_nettype none

module pfdt_table #(
    parameter int unsigned DEPTH = pfdt_pkg::MAX_DEVICES_DEF,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire                   i_clk,
    input  wire                   i_we,
    input  wire [ADDR_W-1:0]      i_waddr,
    input  pfdt_pkg::t_entry      i_wdata,
    input  wire [ADDR_W-1:0]      i_raddr,
    output pfdt_pkg::t_entry      o_rdata
);

    pfdt_pkg::t_entry r_mem [DEPTH];
    pfdt_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/probe_fingerprint_device_tracker.sv */
// Probe fingerprint device tracker. Each accepted frame is matched against the
// device table, one entry per clock, in creation order, through a single match
// unit (fingerprint compare plus sequence and time gap checks on one registered
// table read). A frame that joins entry k scans entries 0 to k, then enters the
// hold state; one that creates a new entry or is dropped on a full table scans
// every stored entry (none when empty), then the append and hold states; one past
// the frame limit goes straight to hold. One frame is in work at a time; a
// finished result sits in an output register, so the next frame is taken while
// it waits. Configuration writes apply at once and belong only to idle periods.
// Depends on pfdt_pkg, pfdt_frame_if, pfdt_result_if, pfdt_table and the
// assertion macro header.
`default_nettype none

`include "probe_fingerprint_device_tracker_assert.svh"

module probe_fingerprint_device_tracker #(
    parameter int unsigned MAX_DEVICES = pfdt_pkg::MAX_DEVICES_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    pfdt_frame_if.sink                         i_frame,
    pfdt_result_if.source                      o_result,
    input  wire                                i_cfg_we,
    input  wire [pfdt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [pfdt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int unsigned ADDR_W = $clog2(MAX_DEVICES);
    localparam int unsigned CNT_W  = $clog2(MAX_DEVICES + 1);
    localparam int unsigned SEQ_W  = pfdt_pkg::SEQ_W;
    localparam int unsigned TIME_W = pfdt_pkg::TIME_W;
    localparam int unsigned OIDX_W = pfdt_pkg::OIDX_W;
    localparam int unsigned OCNT_W = pfdt_pkg::OCNT_W;
    localparam int unsigned FRAMES_W = pfdt_pkg::FRAMES_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_DEVICES);

    // Configuration registers
    logic [SEQ_W-1:0]              r_max_seq_gap;
    logic [TIME_W-1:0]             r_max_time_gap;
    logic [pfdt_pkg::FRAMES_W-1:0] r_frame_limit;

    // Control state
    pfdt_pkg::t_state              r_state, n_state;
    logic [ADDR_W-1:0]             r_idx, n_idx;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [pfdt_pkg::FRAMES_W-1:0] r_frames, n_frames;

    // Frame in work
    logic [SEQ_W-1:0]              r_seq;
    logic [TIME_W-1:0]             r_time;
    logic [pfdt_pkg::FP_W-1:0]     r_fp;

    // Result of the frame in work
    pfdt_pkg::t_status             r_res_status, n_res_status;
    logic [ADDR_W-1:0]             r_res_idx, n_res_idx;

    // Output register
    logic                          r_out_valid;
    pfdt_pkg::t_status             r_out_status;
    logic [OIDX_W-1:0]             r_out_idx;
    logic [OCNT_W-1:0]             r_out_count;

    // Table port
    logic                          w_we;
    logic [ADDR_W-1:0]             w_waddr;
    pfdt_pkg::t_entry              w_wdata;
    logic [ADDR_W-1:0]             w_raddr;
    pfdt_pkg::t_entry              w_rd;

    logic                          w_accept;
    logic                          w_load_out;
    logic [CNT_W-1:0]              w_next;
    logic [SEQ_W:0]                w_seq_diff;
    logic [TIME_W:0]               w_time_diff;
    logic                          w_seq_ok;
    logic                          w_time_ok;
    logic                          w_match;
    logic [ADDR_W+OIDX_W-1:0]      w_idx_ext;
    logic [CNT_W+OCNT_W-1:0]       w_cnt_ext;

    pfdt_table #(
        .DEPTH (MAX_DEVICES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    // Shared match unit: gaps positive, seq gap <= limit, time gap < limit
    assign w_seq_diff  = {1'b0, r_seq} - {1'b0, w_rd.last_seq};
    assign w_time_diff = {1'b0, r_time} - {1'b0, w_rd.last_time};
    assign w_seq_ok    = !w_seq_diff[SEQ_W] && (w_seq_diff[SEQ_W-1:0] != '0) &&
                         (w_seq_diff[SEQ_W-1:0] <= r_max_seq_gap);
    assign w_time_ok   = !w_time_diff[TIME_W] && (w_time_diff[TIME_W-1:0] != '0) &&
                         (w_time_diff[TIME_W-1:0] < r_max_time_gap);
    assign w_match     = (w_rd.fingerprint == r_fp) && w_seq_ok && w_time_ok;

    assign w_next      = CNT_W'(r_idx) + CNT_W'(1);
    assign w_accept    = i_frame.valid && i_frame.ready;
    assign w_wdata     = '{fingerprint: r_fp, last_seq: r_seq, last_time: r_time};

    assign i_frame.ready = (r_state == pfdt_pkg::S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_count      = r_count;
        n_frames     = r_frames;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        w_we         = 1'b0;
        w_waddr      = r_idx;
        w_raddr      = '0;
        w_load_out   = 1'b0;
        unique case (r_state)
            pfdt_pkg::S_IDLE: begin
                n_idx = '0;
                if (w_accept) begin
                    if (r_frames >= r_frame_limit) begin
                        n_res_status = pfdt_pkg::ST_IGNORED;
                        n_res_idx    = '0;
                        n_state      = pfdt_pkg::S_HOLD;
                    end else begin
                        n_frames = r_frames + FRAMES_W'(1);
                        n_state  = (r_count == '0) ? pfdt_pkg::S_APPEND : pfdt_pkg::S_SCAN;
                    end
                end
            end
            pfdt_pkg::S_SCAN: begin
                // prefetch the following entry while comparing this one
                w_raddr = w_next[ADDR_W-1:0];
                if (w_match) begin
                    w_we         = 1'b1;
                    w_waddr      = r_idx;
                    n_res_status = pfdt_pkg::ST_JOINED;
                    n_res_idx    = r_idx;
                    n_state      = pfdt_pkg::S_HOLD;
                end else if (w_next == r_count) begin
                    n_state = pfdt_pkg::S_APPEND;
                end else begin
                    n_idx = w_next[ADDR_W-1:0];
                end
            end
            pfdt_pkg::S_APPEND: begin
                if (r_count == FULL_COUNT) begin
                    n_res_status = pfdt_pkg::ST_FULL;
                    n_res_idx    = '0;
                end else begin
                    w_we         = 1'b1;
                    w_waddr      = r_count[ADDR_W-1:0];
                    n_count      = r_count + CNT_W'(1);
                    n_res_status = pfdt_pkg::ST_NEW;
                    n_res_idx    = r_count[ADDR_W-1:0];
                end
                n_state = pfdt_pkg::S_HOLD;
            end
            pfdt_pkg::S_HOLD: begin
                // hold until the output register is free
                if (!r_out_valid || o_result.ready) begin
                    w_load_out = 1'b1;
                    n_state    = pfdt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pfdt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pfdt_pkg::S_IDLE;
            r_idx        <= '0;
            r_count      <= '0;
            r_frames     <= '0;
            r_res_status <= pfdt_pkg::ST_JOINED;
            r_res_idx    <= '0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_count      <= n_count;
            r_frames     <= n_frames;
            r_res_status <= n_res_status;
            r_res_idx    <= n_res_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_seq  <= i_frame.seq_number;
            r_time <= i_frame.time_ms;
            r_fp   <= i_frame.fingerprint;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_seq_gap  <= pfdt_pkg::MAX_SEQ_GAP_RST;
            r_max_time_gap <= pfdt_pkg::MAX_TIME_GAP_RST;
            r_frame_limit  <= pfdt_pkg::FRAME_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pfdt_pkg::CFG_MAX_SEQ_GAP:  r_max_seq_gap  <= i_cfg_data[SEQ_W-1:0];
                pfdt_pkg::CFG_MAX_TIME_GAP: r_max_time_gap <= i_cfg_data[TIME_W-1:0];
                pfdt_pkg::CFG_FRAME_LIMIT:
                    r_frame_limit <= i_cfg_data[pfdt_pkg::FRAMES_W-1:0];
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    // Keep only the low bits of index and count for the result fields
    assign w_idx_ext = {{OIDX_W{1'b0}}, r_res_idx};
    assign w_cnt_ext = {{OCNT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_status <= r_res_status;
            r_out_idx    <= w_idx_ext[OIDX_W-1:0];
            r_out_count  <= w_cnt_ext[OCNT_W-1:0];
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.status       = r_out_status;
    assign o_result.device_index = r_out_idx;
    assign o_result.device_count = r_out_count;

    `PFDT_ASSERT_NOW(a_count_bounded, i_clk, i_rst_n, 1'b1, r_count <= FULL_COUNT)
    `PFDT_ASSERT_NOW(a_scan_in_table, i_clk, i_rst_n, r_state == pfdt_pkg::S_SCAN,
                     CNT_W'(r_idx) < r_count)
    `PFDT_ASSERT_NEXT(a_count_steps, i_clk, i_rst_n, 1'b1,
                      r_count == $past(r_count) || r_count == $past(r_count) + CNT_W'(1))
    `PFDT_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, w_accept,
                      r_state != pfdt_pkg::S_IDLE)
    `PFDT_ASSERT_NOW(a_result_from_hold, i_clk, i_rst_n, $rose(r_out_valid),
                     $past(r_state) == pfdt_pkg::S_HOLD)

endmodule

`default_nettype wire

/* tb/probe_fingerprint_device_tracker_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for probe_fingerprint_device_tracker: frames go in through
// a queue-fed driver, results are checked against a built-in table tracker model.
// Depends on pfdt_pkg, pfdt_frame_if, pfdt_result_if and the tracker RTL.

module probe_fingerprint_device_tracker_tb;

    localparam int unsigned SEQ_W      = pfdt_pkg::SEQ_W;
    localparam int unsigned TIME_W     = pfdt_pkg::TIME_W;
    localparam int unsigned FP_W       = pfdt_pkg::FP_W;
    localparam int unsigned OIDX_W     = pfdt_pkg::OIDX_W;
    localparam int unsigned OCNT_W     = pfdt_pkg::OCNT_W;
    localparam int unsigned FRAMES_W   = pfdt_pkg::FRAMES_W;
    localparam int unsigned CFG_IDX_W  = pfdt_pkg::CFG_IDX_W;
    localparam int unsigned CFG_DATA_W = pfdt_pkg::CFG_DATA_W;

    localparam int unsigned TABLE_SIZE = pfdt_pkg::MAX_DEVICES_DEF;
    localparam int unsigned POOL_SIZE  = 8;
    localparam int unsigned CYCLE_CAP  = 600000;
    localparam int unsigned DRAIN_CYCLES = 80;

    typedef struct {
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] stamp;
        logic [FP_W-1:0]   fp;
    } t_probe;

    typedef struct {
        pfdt_pkg::t_status status;
        logic [OIDX_W-1:0] idx;
        logic [OCNT_W-1:0] cnt;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    pfdt_frame_if  frm_ch ();
    pfdt_result_if res_ch ();

    probe_fingerprint_device_tracker i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_frame    (frm_ch),
        .o_result   (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Tracker model state
    logic [FP_W-1:0]     dev_fp    [TABLE_SIZE];
    logic [SEQ_W-1:0]    dev_seq   [TABLE_SIZE];
    logic [TIME_W-1:0]   dev_stamp [TABLE_SIZE];
    int unsigned         dev_total;
    logic [FRAMES_W-1:0] frames_seen;
    logic [SEQ_W-1:0]    lim_seq;
    logic [TIME_W-1:0]   lim_time;
    logic [FRAMES_W-1:0] lim_frames;

    // Stimulus device pool: base sequence and time per fingerprint for new frames
    logic [FP_W-1:0]   pool_fp    [POOL_SIZE];
    logic [SEQ_W-1:0]  pool_seq   [POOL_SIZE];
    logic [TIME_W-1:0] pool_stamp [POOL_SIZE];

    t_probe   probes[$];
    t_verdict verdicts[$];
    t_probe   sent;
    bit       idle_on = 1'b1;
    int       gap_left;
    int       stall_left;
    int       n_errors = 0;
    int       n_results = 0;
    int       status_hits[4] = '{0, 0, 0, 0};
    int unsigned cycles = 0;

    function automatic t_verdict track_probe(input t_probe p);
        t_verdict v;
        longint   dseq;
        longint   dt;
        bit       hit;
        v.status = pfdt_pkg::ST_IGNORED;
        v.idx = '0;
        hit = 1'b0;
        if (frames_seen < lim_frames) begin
            frames_seen = frames_seen + FRAMES_W'(1);
            for (int i = 0; i < dev_total && !hit; i++) begin
                dseq = longint'(p.seq) - longint'(dev_seq[i]);
                dt = longint'(p.stamp) - longint'(dev_stamp[i]);
                if (dev_fp[i] == p.fp && dseq > 0 && dseq <= longint'(lim_seq)
                        && dt > 0 && dt < longint'(lim_time)) begin
                    dev_seq[i] = p.seq;
                    dev_stamp[i] = p.stamp;
                    v.idx = i[OIDX_W-1:0];
                    hit = 1'b1;
                end
            end
            if (hit) begin
                v.status = pfdt_pkg::ST_JOINED;
            end else if (dev_total < TABLE_SIZE) begin
                dev_fp[dev_total] = p.fp;
                dev_seq[dev_total] = p.seq;
                dev_stamp[dev_total] = p.stamp;
                v.idx = dev_total[OIDX_W-1:0];
                dev_total++;
                v.status = pfdt_pkg::ST_NEW;
            end else begin
                v.status = pfdt_pkg::ST_FULL;
            end
        end
        v.cnt = dev_total[OCNT_W-1:0];
        return v;
    endfunction

    task automatic add_probe(input logic [SEQ_W-1:0] seq, input logic [TIME_W-1:0] stamp,
                             input logic [FP_W-1:0] fp);
        t_probe p;
        p.seq = seq;
        p.stamp = stamp;
        p.fp = fp;
        probes = {probes, p};
    endtask

    // Well-formed device sequences with random content, plus broken ones and noise
    task automatic add_traffic(input int n, input int noise_pct, input int unsigned seq_cap,
                               input int unsigned time_cap, input bit keep_pool);
        t_probe p;
        int     k;
        int     r;
        for (int j = 0; j < n; j++) begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, POOL_SIZE - 1);
            p.fp = pool_fp[k];
            p.seq = pool_seq[k] + SEQ_W'($urandom_range(1, seq_cap));
            p.stamp = pool_stamp[k] + TIME_W'($urandom_range(1, time_cap));
            if (r < noise_pct) begin
                p.fp = FP_W'($urandom);
                p.seq = SEQ_W'($urandom);
                p.stamp = $urandom;
            end else if (r < noise_pct + 6) begin
                p.seq = pool_seq[k] - SEQ_W'($urandom_range(0, 2));
            end else if (r < noise_pct + 10) begin
                p.seq = pool_seq[k] + SEQ_W'(seq_cap) + SEQ_W'($urandom_range(1, 40));
            end else if (r < noise_pct + 14) begin
                p.stamp = pool_stamp[k] + TIME_W'(time_cap) + TIME_W'(1);
            end else if (r < noise_pct + 24) begin
                // exact upper edges of both gaps
                p.seq = pool_seq[k] + SEQ_W'(seq_cap);
                p.stamp = pool_stamp[k] + TIME_W'(time_cap);
            end
            if (!keep_pool && r >= noise_pct) begin
                pool_seq[k] = p.seq;
                pool_stamp[k] = p.stamp;
            end
            probes = {probes, p};
        end
    endtask

    // Idle means nothing queued, nothing offered and nothing outstanding
    task automatic wait_idle();
        do @(negedge i_clk);
        while (probes.size() != 0 || frm_ch.valid || verdicts.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            pfdt_pkg::CFG_MAX_SEQ_GAP:  lim_seq = val[SEQ_W-1:0];
            pfdt_pkg::CFG_MAX_TIME_GAP: lim_time = val[TIME_W-1:0];
            pfdt_pkg::CFG_FRAME_LIMIT:  lim_frames = val[FRAMES_W-1:0];
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : drive_probes
        t_probe nxt;
        if (!i_rst_n) begin
            frm_ch.valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (frm_ch.valid && frm_ch.ready) begin
                verdicts = {verdicts, track_probe(sent)};
            end
            if (frm_ch.valid && !frm_ch.ready) begin
                // hold the offered frame until the transfer
            end else if (gap_left > 0) begin
                gap_left--;
                frm_ch.valid <= 1'b0;
            end else if (idle_on && probes.size() != 0 && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(0, 18);
                frm_ch.valid <= 1'b0;
            end else if (probes.size() != 0) begin
                nxt = probes.pop_front();
                sent = nxt;
                frm_ch.valid <= 1'b1;
                frm_ch.seq_number <= nxt.seq;
                frm_ch.time_ms <= nxt.stamp;
                frm_ch.fingerprint <= nxt.fp;
            end else begin
                frm_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 18);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_verdict want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            n_results++;
            status_hits[res_ch.status]++;
            if (verdicts.size() == 0) begin
                $display("%0t: unexpected result: status %0d index %0d count %0d", $time,
                         res_ch.status, res_ch.device_index, res_ch.device_count);
                n_errors++;
            end else begin
                want = verdicts.pop_front();
                if (res_ch.status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d actual %0d", $time,
                             want.status, res_ch.status);
                    n_errors++;
                end
                if (res_ch.device_index !== want.idx) begin
                    $display("%0t: device_index mismatch: expected %0d actual %0d", $time,
                             want.idx, res_ch.device_index);
                    n_errors++;
                end
                if (res_ch.device_count !== want.cnt) begin
                    $display("%0t: device_count mismatch: expected %0d actual %0d", $time,
                             want.cnt, res_ch.device_count);
                    n_errors++;
                end
            end
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_CAP) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("%0t: timeout with %0d results outstanding", $time, verdicts.size());
        $display("probe_fingerprint_device_tracker_tb NOT OK");
        $finish;
    end

    initial begin : run_sequence
        int unsigned base_frames;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = pfdt_pkg::CFG_MAX_SEQ_GAP;
        cfg_data = '0;
        frm_ch.valid = 1'b0;
        frm_ch.seq_number = '0;
        frm_ch.time_ms = '0;
        frm_ch.fingerprint = '0;
        res_ch.ready = 1'b0;
        dev_total = 0;
        frames_seen = '0;
        lim_seq = pfdt_pkg::MAX_SEQ_GAP_RST;
        lim_time = pfdt_pkg::MAX_TIME_GAP_RST;
        lim_frames = pfdt_pkg::FRAME_LIMIT_RST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: gap edges, backward steps, field extremes, first-match order
        add_probe(12'd0, 32'd0, 16'h0000);
        add_probe(12'd1, 32'd1, 16'h0000);
        add_probe(12'd1, 32'd2, 16'h0000);
        add_probe(12'd65, 32'd3, 16'h0000);
        add_probe(12'd130, 32'd4, 16'h0000);
        add_probe(12'd131, 32'd10004, 16'h0000);
        add_probe(12'd132, 32'd20003, 16'h0000);
        add_probe(12'd131, 32'd20004, 16'h0000);
        add_probe(12'hFFF, 32'hFFFF_FFFF, 16'hFFFF);
        add_probe(12'h000, 32'h0000_0000, 16'hFFFF);
        add_probe(12'hFFF, 32'hFFFF_FFFE, 16'hFFFF);
        add_probe(12'hAAA, 32'hAAAA_AAAA, 16'hAAAA);
        add_probe(12'h555, 32'h5555_5555, 16'h5555);
        add_probe(12'h556, 32'h5555_5556, 16'h5555);
        add_probe(12'd10, 32'd100, 16'h1234);
        add_probe(12'd10, 32'd100, 16'h1234);
        add_probe(12'd11, 32'd101, 16'h1234);
        add_probe(12'd11, 32'd102, 16'h1234);
        wait_idle();

        // Widest gaps, full frame budget
        write_reg(pfdt_pkg::CFG_MAX_SEQ_GAP, 32'd4095);
        write_reg(pfdt_pkg::CFG_MAX_TIME_GAP, 32'hFFFF_FFFF);
        write_reg(pfdt_pkg::CFG_FRAME_LIMIT, 32'd65535);
        for (int k = 0; k < POOL_SIZE; k++) begin
            pool_fp[k] = FP_W'($urandom);
            pool_seq[k] = SEQ_W'($urandom_range(0, 1000));
            pool_stamp[k] = $urandom;
        end
        add_traffic(75, 20, 200, 100000, 1'b0);
        wait_idle();
        add_traffic(75, 20, 200, 100000, 1'b0);
        wait_idle();

        // Tightest nonzero gaps
        write_reg(pfdt_pkg::CFG_MAX_SEQ_GAP, 32'd1);
        write_reg(pfdt_pkg::CFG_MAX_TIME_GAP, 32'd2);
        add_traffic(70, 5, 1, 1, 1'b0);
        wait_idle();

        // Zero gaps: nothing can join
        write_reg(pfdt_pkg::CFG_MAX_SEQ_GAP, 32'd0);
        write_reg(pfdt_pkg::CFG_MAX_TIME_GAP, 32'd0);
        add_traffic(12, 0, 1, 1, 1'b1);
        wait_idle();

        // Fill the table and run into drops
        write_reg(pfdt_pkg::CFG_MAX_SEQ_GAP, 32'd64);
        write_reg(pfdt_pkg::CFG_MAX_TIME_GAP, 32'd10000);
        add_traffic(80, 100, 1, 1, 1'b1);
        wait_idle();

        // Frame budget runs out mid-phase, then gets lowered below the count
        base_frames = frames_seen;
        write_reg(pfdt_pkg::CFG_FRAME_LIMIT, base_frames + 5);
        add_traffic(12, 20, 64, 9999, 1'b1);
        wait_idle();
        write_reg(pfdt_pkg::CFG_FRAME_LIMIT, 32'd1);
        add_traffic(6, 50, 64, 9999, 1'b1);
        wait_idle();

        // Back to open budget, no idling on either side
        write_reg(pfdt_pkg::CFG_FRAME_LIMIT, 32'd65535);
        idle_on = 1'b0;
        add_traffic(170, 15, 64, 9999, 1'b0);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (verdicts.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, verdicts.size());
            n_errors++;
        end
        $display("Checked %0d results: %0d joined, %0d new, %0d dropped, %0d ignored",
                 n_results, status_hits[pfdt_pkg::ST_JOINED], status_hits[pfdt_pkg::ST_NEW],
                 status_hits[pfdt_pkg::ST_FULL], status_hits[pfdt_pkg::ST_IGNORED]);
        $display("Final table holds %0d devices after %0d tracked frames", dev_total,
                 frames_seen);
        if (n_errors == 0) begin
            $display("probe_fingerprint_device_tracker_tb OK");
        end else begin
            $display("probe_fingerprint_device_tracker_tb NOT OK");
        end
        $finish;
    end

endmodule

/* probe_fingerprint_device_tracker.f */
+incdir+rtl
rtl/pfdt_pkg.sv
rtl/pfdt_frame_if.sv
rtl/pfdt_result_if.sv
rtl/pfdt_table.sv
rtl/probe_fingerprint_device_tracker.sv
tb/probe_fingerprint_device_tracker_tb.sv
